FILE: hw/rtl/mrp_pkg.sv
`default_nettype none
package mrp_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int COORD_W    = 32;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int CELL_W     = 4;
	localparam int PROD_W     = DIFF_W + CELL_W;
	localparam int KEY_W      = 32;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_QRD,
		ST_QX,
		ST_QXW,
		ST_QY,
		ST_QYW,
		ST_SCAN,
		ST_DECIDE
	} mrp_state_t;

	// floor of the square root of a small count
	function automatic logic [CELL_W-1:0] isqrt(input logic [CNT_W-1:0] n);
		logic [CELL_W-1:0] g;
		g = '0;
		for (int k = 1; k <= 8; k++) begin
			if (k * k <= int'(n))
				g = CELL_W'(k);
		end
		return g;
	endfunction

	// interleave (x even, y odd) and bit-reverse
	function automatic logic [KEY_W-1:0] rev_key(input logic [CELL_W-1:0] cx,
			input logic [CELL_W-1:0] cy);
		logic [KEY_W-1:0] m;
		logic [KEY_W-1:0] r;
		m = '0;
		for (int k = 0; k < CELL_W; k++) begin
			m[2*k]   = cx[k];
			m[2*k+1] = cy[k];
		end
		for (int k = 0; k < KEY_W; k++)
			r[k] = m[KEY_W-1-k];
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mrp_ram.sv
`default_nettype none
module mrp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: hw/rtl/mrp_cell_div.sv
`default_nettype none
module mrp_cell_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [mrp_pkg::DIFF_W-1:0]        diff,
	input  wire logic [mrp_pkg::DIFF_W-1:0]        range,
	input  wire logic [mrp_pkg::CELL_W-1:0]        grid,
	output logic                                   done,
	output logic      [mrp_pkg::CELL_W-1:0]        quot
);

	logic                              busy_q;
	logic [1:0]                        step_q;
	logic [mrp_pkg::PROD_W-1:0]        rem_q;
	logic [mrp_pkg::DIFF_W-1:0]        rng_q;
	logic                              zero_q;
	logic [mrp_pkg::CELL_W-1:0]        quo_q;
	logic [mrp_pkg::PROD_W-1:0]        sub;
	logic                              ge;

	// one compare and subtract a cycle, quotient bit 3 down to 0
	assign sub = {{mrp_pkg::CELL_W{1'b0}}, rng_q} << step_q;
	assign ge  = rem_q >= sub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && step_q == 2'd0) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= mrp_pkg::PROD_W'(diff) * mrp_pkg::PROD_W'(grid);
			rng_q  <= range;
			zero_q <= range == '0;
			step_q <= 2'd3;
			quo_q  <= '0;
		end else if (busy_q) begin
			if (ge && !zero_q) begin
				rem_q         <= rem_q - sub;
				quo_q[step_q] <= 1'b1;
			end
			step_q <= step_q - 2'd1;
			if (step_q == 2'd0)
				quot <= (ge && !zero_q) ? (quo_q | 4'd1) : quo_q;
		end
	end

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q)) else $error("cell done without work");

endmodule
`default_nettype wire

FILE: hw/rtl/morton_reverse_point_reorder.sv
`default_nettype none
// reversed-morton point reorder: points are loaded one word per cycle while
// busy is low (start high, busy low accepts a word). the word with last_point
// set closes the set; busy then rises while each point is put on a grid of
// side floor(sqrt(count)) and given a bit-reversed morton key. each point
// goes through the shared compare-subtract cell divider (x then y). the
// sort is a selection pass over the key memory, repeated until no key is
// left. results come out on valid for one cycle each and cannot be
// stalled; last_out flags the final word. points sharing a key keep only
// the latest loaded one. points past 64 are dropped.
module morton_reverse_point_reorder (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic signed [mrp_pkg::COORD_W-1:0] x_coord,
	input  wire logic signed [mrp_pkg::COORD_W-1:0] y_coord,
	input  wire logic                               last_point,
	output logic                                    valid,
	output logic             [mrp_pkg::IDX_W-1:0]   point_index,
	output logic                                    last_out
);

	mrp_pkg::mrp_state_t state_q, state_d;

	// set bookkeeping
	logic        [mrp_pkg::CNT_W-1:0]   count_q;
	logic signed [mrp_pkg::COORD_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic        [mrp_pkg::CELL_W-1:0]  grid_q;
	logic        [mrp_pkg::IDX_W-1:0]   idx_q;
	logic        [mrp_pkg::CELL_W-1:0]  cx_q;

	// sort pass
	logic        [mrp_pkg::CNT_W-1:0]   scan_q;
	logic        [mrp_pkg::IDX_W-1:0]   scan_s1;
	logic                               scan_v_s1;
	logic                               first_q;
	logic                               found_q;
	logic        [mrp_pkg::IDX_W-1:0]   best_idx_q;
	logic        [mrp_pkg::KEY_W-1:0]   best_key_q;
	logic        [mrp_pkg::KEY_W-1:0]   prev_key_q;
	logic                               pend_q;
	logic        [mrp_pkg::IDX_W-1:0]   pend_idx_q;

	// memories
	logic                               pt_we;
	logic        [mrp_pkg::COORD_W-1:0] x_rd, y_rd;
	logic                               key_we;
	logic        [mrp_pkg::KEY_W-1:0]   key_wd, key_rd;

	// divider hook-up
	logic                               div_start, div_done;
	logic        [mrp_pkg::DIFF_W-1:0]  div_diff, div_range;
	logic        [mrp_pkg::CELL_W-1:0]  div_cell;

	logic                               accept;
	logic                               room;
	logic                               last_idx;
	logic                               cand;

	assign accept   = start && state_q == mrp_pkg::ST_LOAD;
	assign room     = count_q < mrp_pkg::CNT_W'(mrp_pkg::MAX_POINTS);
	assign pt_we    = accept && room;
	assign busy     = state_q != mrp_pkg::ST_LOAD;
	assign last_idx = ({1'b0, idx_q} + 1'b1) == count_q;

	mrp_ram #(.WIDTH(mrp_pkg::COORD_W), .DEPTH(mrp_pkg::MAX_POINTS)) u_x_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (count_q[mrp_pkg::IDX_W-1:0]),
		.wdata (x_coord),
		.raddr (idx_q),
		.rdata (x_rd)
	);

	mrp_ram #(.WIDTH(mrp_pkg::COORD_W), .DEPTH(mrp_pkg::MAX_POINTS)) u_y_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (count_q[mrp_pkg::IDX_W-1:0]),
		.wdata (y_coord),
		.raddr (idx_q),
		.rdata (y_rd)
	);

	mrp_ram #(.WIDTH(mrp_pkg::KEY_W), .DEPTH(mrp_pkg::MAX_POINTS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (idx_q),
		.wdata (key_wd),
		.raddr (scan_q[mrp_pkg::IDX_W-1:0]),
		.rdata (key_rd)
	);

	function automatic logic [mrp_pkg::DIFF_W-1:0] DIFF_W_sub(
			input logic signed [mrp_pkg::COORD_W-1:0] a,
			input logic signed [mrp_pkg::COORD_W-1:0] b);
		return {a[mrp_pkg::COORD_W-1], a} - {b[mrp_pkg::COORD_W-1], b};
	endfunction

	// x pass then y pass through the one divider
	always_comb begin
		if (state_q == mrp_pkg::ST_QX) begin
			div_diff  = DIFF_W_sub(x_rd, min_x_q);
			div_range = DIFF_W_sub(max_x_q, min_x_q);
		end else begin
			div_diff  = DIFF_W_sub(y_rd, min_y_q);
			div_range = DIFF_W_sub(max_y_q, min_y_q);
		end
	end

	assign div_start = state_q == mrp_pkg::ST_QX || state_q == mrp_pkg::ST_QY;

	mrp_cell_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.diff   (div_diff),
		.range  (div_range),
		.grid   (grid_q),
		.done   (div_done),
		.quot   (div_cell)
	);

	assign key_we = state_q == mrp_pkg::ST_QYW && div_done;
	assign key_wd = mrp_pkg::rev_key(cx_q, div_cell);

	// candidate: above the last chosen key, not above the best so far;
	// a tie takes the later point, which is the one kept
	assign cand = (first_q || key_rd > prev_key_q) && (!found_q || key_rd <= best_key_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mrp_pkg::ST_LOAD:   if (accept && last_point) state_d = mrp_pkg::ST_QRD;
			mrp_pkg::ST_QRD:    state_d = mrp_pkg::ST_QX;
			mrp_pkg::ST_QX:     state_d = mrp_pkg::ST_QXW;
			mrp_pkg::ST_QXW:    if (div_done) state_d = mrp_pkg::ST_QY;
			mrp_pkg::ST_QY:     state_d = mrp_pkg::ST_QYW;
			mrp_pkg::ST_QYW: begin
				if (div_done)
					state_d = last_idx ? mrp_pkg::ST_SCAN : mrp_pkg::ST_QRD;
			end
			mrp_pkg::ST_SCAN:   if (scan_q == count_q && scan_v_s1) state_d = mrp_pkg::ST_DECIDE;
			mrp_pkg::ST_DECIDE: state_d = found_q ? mrp_pkg::ST_SCAN : mrp_pkg::ST_LOAD;
			default:            state_d = mrp_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mrp_pkg::ST_LOAD;
		else
			state_q <= state_d;
	end

	// load, bounding box and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_x_q <= '0;
			max_x_q <= '0;
			min_y_q <= '0;
			max_y_q <= '0;
			idx_q   <= '0;
			scan_q  <= '0;
			scan_v_s1 <= 1'b0;
			first_q <= 1'b1;
			found_q <= 1'b0;
			pend_q  <= 1'b0;
			valid   <= 1'b0;
			last_out <= 1'b0;
		end else begin
			valid    <= 1'b0;
			last_out <= 1'b0;
			scan_v_s1 <= 1'b0;
			case (state_q)
				mrp_pkg::ST_LOAD: begin
					if (pt_we) begin
						count_q <= count_q + 1'b1;
						if (count_q == '0) begin
							min_x_q <= x_coord;
							max_x_q <= x_coord;
							min_y_q <= y_coord;
							max_y_q <= y_coord;
						end else begin
							if (x_coord < min_x_q) min_x_q <= x_coord;
							if (x_coord > max_x_q) max_x_q <= x_coord;
							if (y_coord < min_y_q) min_y_q <= y_coord;
							if (y_coord > max_y_q) max_y_q <= y_coord;
						end
					end
					idx_q   <= '0;
					scan_q  <= '0;
					first_q <= 1'b1;
					found_q <= 1'b0;
					pend_q  <= 1'b0;
				end
				mrp_pkg::ST_QYW: begin
					if (div_done && !last_idx)
						idx_q <= idx_q + 1'b1;
				end
				mrp_pkg::ST_SCAN: begin
					if (scan_q != count_q) begin
						scan_q    <= scan_q + 1'b1;
						scan_v_s1 <= 1'b1;
					end
					if (scan_v_s1 && cand)
						found_q <= 1'b1;
				end
				mrp_pkg::ST_DECIDE: begin
					// the word found a pass earlier goes out now, once we know
					// whether anything follows it
					if (pend_q) begin
						valid    <= 1'b1;
						last_out <= !found_q;
					end
					scan_q  <= '0;
					first_q <= 1'b0;
					found_q <= 1'b0;
					pend_q  <= found_q;
					if (!found_q) begin
						count_q <= '0;
						min_x_q <= '0;
						max_x_q <= '0;
						min_y_q <= '0;
						max_y_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == mrp_pkg::ST_QRD)
			grid_q <= mrp_pkg::isqrt(count_q);
		if (state_q == mrp_pkg::ST_QXW && div_done)
			cx_q <= div_cell;
		if (state_q == mrp_pkg::ST_SCAN) begin
			scan_s1 <= scan_q[mrp_pkg::IDX_W-1:0];
			if (scan_v_s1 && cand) begin
				best_idx_q <= scan_s1;
				best_key_q <= key_rd;
			end
		end
		if (state_q == mrp_pkg::ST_DECIDE) begin
			if (pend_q)
				point_index <= pend_idx_q;
			pend_idx_q <= best_idx_q;
			prev_key_q <= best_key_q;
		end
	end

	a_valid_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(state_q == mrp_pkg::ST_DECIDE)) else $error("word outside decide");

	a_last_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_out |-> valid) else $error("last flag without word");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mrp_pkg::CNT_W'(mrp_pkg::MAX_POINTS)) else $error("count overflow");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mrp_pkg::ST_LOAD && start && last_point) |=> busy)
		else $error("last point did not start reorder");

endmodule
`default_nettype wire
